FILE: rtl/deq_pkg.sv
// deq_pkg: shared types, constants and ring index helpers for the deque block
// no dependencies; compiled first

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMDQ_DEPTH = 2;
    localparam int QP_W       = $clog2(CMDQ_DEPTH);
    localparam int QC_W       = $clog2(CMDQ_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t CNT_DEPTH = cnt_t'(DEPTH);

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_READ_FWD   = 3'd4,
        FN_READ_REV   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OPK_PUSH,
        OPK_POP,
        OPK_READ
    } op_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_READOUT
    } back_state_t;

    // at_front: push/pop at front, or read front to back
    typedef struct packed {
        op_kind_t                 kind;
        logic                     at_front;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t status;
        logic    last;
        logic    use_ram;
    } rsp_ctl_t;

    function automatic idx_t ring_add(idx_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt_t'(base)} + {1'b0, off};
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic idx_t ring_inc(idx_t base);
        return (base == idx_t'(DEPTH - 1)) ? '0 : base + idx_t'(1);
    endfunction

    function automatic idx_t ring_dec(idx_t base);
        return (base == '0) ? idx_t'(DEPTH - 1) : base - idx_t'(1);
    endfunction

endpackage

FILE: rtl/deq_if.sv
// deq_in_if / deq_out_if: valid-ready channels for request and response beats
// depends on deq_pkg

interface deq_in_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [2:0]               func;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] element;
    logic [1:0]               status;
    logic                     last;

    modport source (output valid, output element, output status, output last, input ready);
    modport sink   (input valid, input element, input status, input last, output ready);
endinterface

FILE: rtl/double_ended_queue_top.sv
// double_ended_queue_top: deque of signed words in a ring store
// depends on deq_pkg, deq_if, deq_front, deq_cmdq, deq_back (with deq_ram)
//
//  channel  dir  fields                    beat
//  req      in   func, value               one operation
//  rsp      out  element, status, last     one result (read-out: one per entry)
//
// push and pop each issue as a single command; a read-out issues one ram read per stored
// entry, in turn, through the single read port of the ring store ram
// a request passes the command fifo, the ram read and the response register
// reset clears pointers, count and all valid flags; the store contents are not cleared
// a stalled response holds the back part; the command fifo still takes two requests

module double_ended_queue_top (
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    req,
    deq_out_if.source rsp
);
    import deq_pkg::*;

    cmd_t front_cmd, back_cmd;
    logic front_valid, front_ready;
    logic back_valid, back_ready;

    deq_front u_front (
        .req       (req),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    deq_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (back_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    deq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .rsp       (rsp)
    );
endmodule

FILE: rtl/deq_ram.sv
// deq_ram: generic single write port, single read port ram with registered read
// no dependencies

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: rtl/deq_front.sv
// deq_front: takes request beats and sorts them into push, pop and read commands
// depends on deq_pkg and deq_in_if

module deq_front (
    deq_in_if.sink          req,
    output deq_pkg::cmd_t   cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);
    import deq_pkg::*;

    logic known;

    always_comb
    begin
        cmd.value    = req.value;
        cmd.kind     = OPK_PUSH;
        cmd.at_front = 1'b0;
        known        = 1'b1;
        unique case (func_t'(req.func))
            FN_PUSH_FRONT:
            begin
                cmd.kind     = OPK_PUSH;
                cmd.at_front = 1'b1;
            end
            FN_PUSH_BACK:
            begin
                cmd.kind     = OPK_PUSH;
                cmd.at_front = 1'b0;
            end
            FN_POP_FRONT:
            begin
                cmd.kind     = OPK_POP;
                cmd.at_front = 1'b1;
            end
            FN_POP_BACK:
            begin
                cmd.kind     = OPK_POP;
                cmd.at_front = 1'b0;
            end
            FN_READ_FWD:
            begin
                cmd.kind     = OPK_READ;
                cmd.at_front = 1'b1;
            end
            FN_READ_REV:
            begin
                cmd.kind     = OPK_READ;
                cmd.at_front = 1'b0;
            end
            default:
            begin
                // undefined codes are taken and dropped
                known = 1'b0;
            end
        endcase
    end

    assign cmd_valid = req.valid && known;
    assign req.ready = cmd_ready;
endmodule

FILE: rtl/deq_cmdq.sv
// deq_cmdq: short command fifo between the front and back parts
// depends on deq_pkg

module deq_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  deq_pkg::cmd_t in_cmd,
    input  logic          in_valid,
    output logic          in_ready,
    output deq_pkg::cmd_t out_cmd,
    output logic          out_valid,
    input  logic          out_ready
);
    import deq_pkg::*;

    cmd_t              q_reg [CMDQ_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   cnt_reg, cnt_next;
    logic              push, pop;

    assign in_ready  = (cnt_reg != QC_W'(CMDQ_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QP_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QP_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QC_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

FILE: rtl/deq_back.sv
// deq_back: executes commands on the ring store, sequences read-outs,
// and drives the response register; depends on deq_pkg, deq_out_if, deq_ram

module deq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  deq_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    deq_out_if.source     rsp
);
    import deq_pkg::*;

    back_state_t state_reg, state_next;
    idx_t        front_reg, front_next;
    cnt_t        cnt_reg, cnt_next;
    idx_t        idx_reg, idx_next;
    logic        rev_reg, rev_next;
    logic        s1_valid_reg, s1_valid_next;
    rsp_ctl_t    s1_reg, s1_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [DATA_W-1:0] out_elem_reg;
    status_t                  out_status_reg;
    logic                     out_last_reg;

    logic              ram_we, ram_re;
    idx_t              ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic s1_move, can_issue, last_now;
    cnt_t ro_off;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ram data stays put while stage one waits, since a read is only issued on advance
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign can_issue = !s1_valid_reg || s1_move;
    assign last_now  = ((cnt_t'(idx_reg) + cnt_t'(1)) == cnt_reg);
    assign ro_off    = rev_reg ? (cnt_reg - cnt_t'(1) - cnt_t'(idx_reg)) : cnt_t'(idx_reg);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        rev_next      = rev_reg;
        s1_valid_next = s1_valid_reg && !s1_move;
        s1_next       = s1_reg;
        cmd_ready     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = front_reg;
        ram_raddr     = front_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = can_issue;
                if (cmd_valid && can_issue)
                begin
                    s1_valid_next = 1'b1;
                    s1_next       = '{status: ST_OK, last: 1'b1, use_ram: 1'b0};
                    unique case (cmd.kind)
                        OPK_PUSH:
                        begin
                            if (cnt_reg == CNT_DEPTH)
                            begin
                                s1_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + cnt_t'(1);
                                if (cmd.at_front)
                                begin
                                    front_next = ring_dec(front_reg);
                                    ram_waddr  = ring_dec(front_reg);
                                end
                                else
                                begin
                                    ram_waddr = ring_add(front_reg, cnt_reg);
                                end
                            end
                        end
                        OPK_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                s1_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re          = 1'b1;
                                s1_next.use_ram = 1'b1;
                                cnt_next        = cnt_reg - cnt_t'(1);
                                if (cmd.at_front)
                                begin
                                    ram_raddr  = front_reg;
                                    front_next = ring_inc(front_reg);
                                end
                                else
                                begin
                                    ram_raddr = ring_add(front_reg, cnt_reg - cnt_t'(1));
                                end
                            end
                        end
                        OPK_READ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                s1_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re          = 1'b1;
                                s1_next.use_ram = 1'b1;
                                s1_next.last    = (cnt_reg == cnt_t'(1));
                                ram_raddr       = ring_add(front_reg,
                                    cmd.at_front ? cnt_t'(0) : cnt_reg - cnt_t'(1));
                                rev_next        = !cmd.at_front;
                                idx_next        = idx_t'(1);
                                if (cnt_reg != cnt_t'(1))
                                begin
                                    state_next = BK_READOUT;
                                end
                            end
                        end
                        default:
                        begin
                            s1_valid_next = s1_valid_reg && !s1_move;
                        end
                    endcase
                end
            end
            BK_READOUT:
            begin
                if (can_issue)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = ring_add(front_reg, ro_off);
                    s1_valid_next = 1'b1;
                    s1_next       = '{status: ST_OK, last: last_now, use_ram: 1'b1};
                    idx_next      = idx_reg + idx_t'(1);
                    if (last_now)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            front_reg     <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            rev_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_reg        <= '{status: ST_OK, last: 1'b0, use_ram: 1'b0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            rev_reg       <= rev_next;
            s1_valid_reg  <= s1_valid_next;
            s1_reg        <= s1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_elem_reg   <= s1_reg.use_ram ? $signed(ram_rdata) : '0;
            out_status_reg <= s1_reg.status;
            out_last_reg   <= s1_reg.last;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.element = out_elem_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.last    = out_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_DEPTH)
        else $error("entry count above depth");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
        (cnt_reg == $past(cnt_reg) + cnt_t'(1) || cnt_reg == $past(cnt_reg) - cnt_t'(1)))
        else $error("entry count moved by more than one");

    a_no_write_readout: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READOUT) |-> !ram_we)
        else $error("store written during read-out");

    a_readout_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READOUT) |-> (cnt_reg > cnt_t'(1)))
        else $error("read-out running with fewer than two entries");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("stalled stage one beat lost or changed");
`endif
endmodule
